// ----- hdl/isort_pkg.sv -----
// isort_pkg: shared command and status types for the insertion sorter
// used by isort_ctrl, isort_datapath and insertion_sorter_core; no dependencies
package isort_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic insert;   // place the input value into the sorted cells
		logic drop;     // store full, discard the input value
		logic pop;      // result taken, shift cells down by one
	} isort_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;     // every cell holds a value
		logic one_left; // exactly one value remains
	} isort_status_t;

endpackage

// ----- hdl/isort_ctrl.sv -----
// isort_ctrl: load/drain state machine and handshake control for the sorter
// depends on isort_pkg
module isort_ctrl
	import isort_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  isort_status_t status,
	output isort_cmd_t    cmd
);

	localparam logic ST_FILL  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic state_d;
	logic in_take;

	assign in_stall  = (state_q != ST_FILL);
	assign out_valid = (state_q == ST_DRAIN);
	assign in_take   = in_valid && (state_q == ST_FILL);

	assign cmd.insert = in_take && !status.full;
	assign cmd.drop   = in_take && status.full;
	assign cmd.pop    = (state_q == ST_DRAIN) && !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_FILL: begin
				if (in_take && last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// final result of the set taken
				if (!out_stall && status.one_left) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/isort_datapath.sv -----
// isort_datapath: row of compare-and-shift cells, fill count and drop flag
// depends on isort_pkg
module isort_datapath
	import isort_pkg::*;
#(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  isort_cmd_t                   cmd,
	input  logic signed [DATA_WIDTH-1:0] value,
	output isort_status_t                status,
	output logic signed [DATA_WIDTH-1:0] sorted_value,
	output logic                         last_res,
	output logic                         dropped
);

	localparam int CW = $clog2(DEPTH + 1);

	logic signed [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]             gt;
	logic [CW-1:0]                count_q;
	logic                         ovf_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_WIDTH-1:0] ins_val;

		// cells are sorted, so gt is set on a contiguous upper run of valid cells
		assign gt[i] = (CW'(i) < count_q) && (cell_q[i] > value);

		if (i == 0) begin : g_first
			// empty row: the first value lands in the bottom cell
			assign ins_val = (gt[i] || (count_q == '0)) ? value : cell_q[i];
		end else begin : g_rest
			always_comb begin
				if (gt[i-1]) begin
					ins_val = cell_q[i-1];
				end else if (gt[i] || (CW'(i) == count_q)) begin
					ins_val = value;
				end else begin
					ins_val = cell_q[i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				cell_q[i] <= ins_val;
			end else if (cmd.pop) begin
				if (i < DEPTH - 1) begin
					cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (cmd.insert) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.drop) begin
				ovf_q <= 1'b1;
			end else if (cmd.pop && status.one_left) begin
				ovf_q <= 1'b0;
			end
		end
	end

	assign status.full     = (count_q == CW'(DEPTH));
	assign status.one_left = (count_q == CW'(1));

	assign sorted_value = cell_q[0];
	assign last_res     = status.one_left;
	assign dropped      = ovf_q;

endmodule

// ----- hdl/insertion_sorter_core.sv -----
// Streaming insertion sorter. Values arrive one per cycle and each is
// inserted into a row of DEPTH compare-and-shift cells; equal values keep
// arrival order. Once the item flagged last is accepted the input stalls
// and the set drains from the bottom cell in ascending order, one result
// per cycle while out_stall is low, then loading resumes. Items that
// arrive with all cells full are discarded and every result of that set
// reports dropped.
// top level; depends on isort_pkg, isort_ctrl and isort_datapath
module insertion_sorter_core
	import isort_pkg::*;
#(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] sorted_value,
	output logic                         last_res,
	output logic                         dropped
);

	isort_cmd_t    cmd;
	isort_status_t status;

	isort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	isort_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.status       (status),
		.sorted_value (sorted_value),
		.last_res     (last_res),
		.dropped      (dropped)
	);

endmodule
